@@ sv/bsc_pkg.sv @@
`timescale 1ns / 1ps

package bsc_pkg;

   localparam int IDX_W = 12;
   localparam int CNT_W = 13;
   localparam int CMD_W = 3;
   localparam int ST_W  = 2;

   localparam logic [CMD_W-1:0] CMD_SET        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TEST       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND_SET   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND_CLEAR = 3'd4;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_INVALID   = 2'd1;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

   localparam logic [CNT_W-1:0] BIT_COUNT_RESET = 13'd4096;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic             bit_value;
      logic [IDX_W-1:0] found_index;
      logic [CNT_W-1:0] set_total;
   } rsp_type;

endpackage

@@ sv/bsc_div.sv @@
`timescale 1ns / 1ps

module bsc_div #(
   parameter int DIVISOR = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bsc_pkg::IDX_W-1:0]        dividend,
   output logic                             done,
   output logic [bsc_pkg::IDX_W-1:0]        quotient,
   output logic [$clog2(DIVISOR)-1:0]       remainder
);
   import bsc_pkg::*;

   // The quotient is the dividend times a rounded-up reciprocal, shifted down; this is exact
   // for every dividend that fits in IDX_W bits. The remainder is registered with the quotient.
   localparam int RM  = $clog2(DIVISOR);
   localparam int SH  = IDX_W + RM;
   localparam int MUL = ((1 << SH) + DIVISOR - 1) / DIVISOR;
   localparam int MW  = $clog2(MUL + 1);
   localparam int PRW = IDX_W + MW;

   logic [PRW-1:0]   prod;
   logic [IDX_W-1:0] back;
   logic [IDX_W-1:0] diff;
   logic [IDX_W-1:0] q1_ff, q1_in;
   logic [IDX_W-1:0] x_ff, x_in;
   logic             v1_ff, v1_in;
   logic [IDX_W-1:0] quot_ff, quot_in;
   logic [RM-1:0]    rem_ff, rem_in;
   logic             done_ff, done_in;

   always_comb begin
      prod    = PRW'(dividend) * PRW'(MUL);
      back    = q1_ff * IDX_W'(DIVISOR);
      diff    = x_ff - back;
      v1_in   = start;
      q1_in   = q1_ff;
      x_in    = x_ff;
      if (start) begin
         q1_in = IDX_W'(prod >> SH);
         x_in  = dividend;
      end
      done_in = v1_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (v1_ff) begin
         quot_in = q1_ff;
         rem_in  = diff[RM-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         done_ff <= done_in;
      end
      q1_ff   <= q1_in;
      x_ff    <= x_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/bsc_mem.sv @@
`timescale 1ns / 1ps

module bsc_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 64
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] words_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= words_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bitmap_set_clear_find_next.sv @@
`timescale 1ns / 1ps

// Flat allocation bitmap: each item sets, clears or tests one bit, or finds the first set or
// clear bit at or after a start index, and every item gives one result with the population
// count after it. The bits live in one memory of WORD_BITS-wide words with a registered read.
// After reset a clearing pass writes zero to every word, one word a cycle (64 words at the
// default size), and no item is taken until it ends. Items are handled one at a time: the index
// is split into word and offset by a registered constant reciprocal multiplication; set, clear
// and test then read the word and update the bit, while a find reads one memory word after
// another until it hits or runs out of words, up to 64 words at the default size. An invalid
// item skips the divider and memory and goes straight to the result register, then to the
// output register. The output register holds a finished result until it is taken, and the
// next item is accepted as soon as the result has moved there.
module bitmap_set_clear_find_next #(
   parameter int TOTAL_BITS = 4096,
   parameter int WORD_BITS  = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [bsc_pkg::CMD_W-1:0]   req_command,
   input  logic [bsc_pkg::IDX_W-1:0]   req_bit_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bsc_pkg::ST_W-1:0]    rsp_status,
   output logic                        rsp_bit_value,
   output logic [bsc_pkg::IDX_W-1:0]   rsp_found_index,
   output logic [bsc_pkg::CNT_W-1:0]   rsp_set_total,
   input  logic                        csr_wr_en,
   input  logic [bsc_pkg::CNT_W-1:0]   csr_wr_data
);
   import bsc_pkg::*;

   localparam int SPAN_BITS  = (TOTAL_BITS < 8192) ? TOTAL_BITS : 8192;
   localparam int WORD_COUNT = (SPAN_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int PL         = $clog2(WORD_BITS);
   localparam int PW         = 1 << PL;
   localparam int BW         = 14;
   localparam int POP_CAP    = (SPAN_BITS < 4096) ? SPAN_BITS : 4096;

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_MOD  = 3'd4;
   localparam logic [2:0] S_SCAN = 3'd5;
   localparam logic [2:0] S_ENC  = 3'd6;
   localparam logic [2:0] S_RESP = 3'd7;

   function automatic logic [PL-1:0] first_set(input logic [PW-1:0] w);
      logic [PW-1:0] v;
      logic [PW-1:0] lo;
      logic [PL-1:0] p;
      v = w;
      p = '0;
      for (int s = PL - 1; s >= 0; s--) begin
         lo = {PW{1'b1}} >> (PW - (1 << s));
         if ((v & lo) == '0) begin
            p[s] = 1'b1;
            v    = v >> (1 << s);
         end
      end
      return p;
   endfunction

   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pop_ff, pop_in;
   logic [CNT_W-1:0] bit_count_ff;
   logic [AW-1:0]    word_ff, word_in;
   logic [PL-1:0]    off_ff, off_in;
   logic [AW-1:0]    iss_addr_ff, iss_addr_in;
   logic [BW-1:0]    iss_base_ff, iss_base_in;
   logic             iss_first_ff, iss_first_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [BW-1:0]    chk_base_ff, chk_base_in;
   logic             chk_first_ff, chk_first_in;
   logic [PW-1:0]    hit_word_ff, hit_word_in;
   logic [BW-1:0]    hit_base_ff, hit_base_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic                 div_start;
   logic                 div_done;
   logic [IDX_W-1:0]     div_quot;
   logic [PL-1:0]        div_rem;

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;

   logic [BW-1:0]        lim;
   logic                 req_bad;
   logic [WORD_BITS-1:0] mod_word;
   logic                 old_bit;
   logic [BW-1:0]        span;
   logic [PW-1:0]        keep;
   logic [PW-1:0]        cand;
   logic                 scan_hit;
   logic                 scan_last;
   logic                 scan_issue;
   logic [BW-1:0]        found;

   bsc_div #(
      .DIVISOR (WORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_bit_index),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   bsc_mem #(
      .DEPTH (WORD_COUNT),
      .AW    (AW),
      .DW    (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign lim = ({1'b0, bit_count_ff} > BW'(SPAN_BITS)) ? BW'(SPAN_BITS) : {1'b0, bit_count_ff};
   assign req_bad = (req_command > CMD_FIND_CLEAR) || ({2'b00, req_bit_index} >= lim);

   always_comb begin
      mod_word          = mem_rd_data;
      mod_word[off_ff]  = (cmd_ff == CMD_SET);
   end
   assign old_bit = mem_rd_data[off_ff];

   assign span = lim - chk_base_ff;
   always_comb begin
      for (int j = 0; j < PW; j++) begin
         keep[j] = (j < WORD_BITS) && (!chk_first_ff || (PL'(j) >= off_ff))
                   && (BW'(j) < span);
      end
   end
   assign cand       = (cmd_ff == CMD_FIND_SET) ? PW'(mem_rd_data) & keep
                                                : PW'(~mem_rd_data) & keep;
   assign scan_hit   = (cand != '0);
   assign scan_last  = (BW'(chk_base_ff + BW'(WORD_BITS)) >= lim);
   assign scan_issue = (iss_base_ff < lim);
   assign found      = hit_base_ff + BW'(first_set(hit_word_ff));

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      pop_in       = pop_ff;
      word_in      = word_ff;
      off_in       = off_ff;
      iss_addr_in  = iss_addr_ff;
      iss_base_in  = iss_base_ff;
      iss_first_in = iss_first_ff;
      chk_vld_in   = 1'b0;
      chk_base_in  = chk_base_ff;
      chk_first_in = chk_first_ff;
      hit_word_in  = hit_word_ff;
      hit_base_in  = hit_base_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = word_ff;
      mem_wr_data  = mod_word;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = iss_addr_ff;
      req_ready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_CLR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(WORD_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               idx_in = req_bit_index;
               if (req_bad) begin
                  res_in   = '{ST_INVALID, 1'b0, '0, pop_ff};
                  state_in = S_RESP;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               word_in      = div_quot[AW-1:0];
               off_in       = div_rem;
               iss_addr_in  = div_quot[AW-1:0];
               iss_base_in  = BW'(idx_ff) - BW'(div_rem);
               iss_first_in = 1'b1;
               state_in     = (cmd_ff == CMD_FIND_SET || cmd_ff == CMD_FIND_CLEAR) ? S_SCAN
                                                                                   : S_RD;
            end
         end
         S_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = word_ff;
            state_in    = S_MOD;
         end
         S_MOD: begin
            priority if (cmd_ff == CMD_SET && !old_bit) begin
               mem_wr_en = 1'b1;
               pop_in    = pop_ff + CNT_W'(1);
            end else if (cmd_ff == CMD_CLEAR && old_bit) begin
               mem_wr_en = 1'b1;
               pop_in    = pop_ff - CNT_W'(1);
            end else begin
               pop_in = pop_ff;
            end
            res_in   = '{ST_OK, old_bit, '0, pop_in};
            state_in = S_RESP;
         end
         S_SCAN: begin
            if (scan_issue) begin
               mem_rd_en    = 1'b1;
               iss_addr_in  = iss_addr_ff + AW'(1);
               iss_base_in  = iss_base_ff + BW'(WORD_BITS);
               iss_first_in = 1'b0;
               chk_vld_in   = 1'b1;
               chk_base_in  = iss_base_ff;
               chk_first_in = iss_first_ff;
            end
            if (chk_vld_ff) begin
               priority if (scan_hit) begin
                  hit_word_in = cand;
                  hit_base_in = chk_base_ff;
                  state_in    = S_ENC;
               end else if (scan_last) begin
                  res_in   = '{ST_NOT_FOUND, 1'b0, '0, pop_ff};
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_ENC: begin
            res_in   = '{ST_OK, 1'b0, found[IDX_W-1:0], pop_ff};
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_addr_ff  <= '0;
         pop_ff       <= '0;
         bit_count_ff <= BIT_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         if (csr_wr_en) begin
            bit_count_ff <= csr_wr_data;
         end
      end
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      word_ff      <= word_in;
      off_ff       <= off_in;
      iss_addr_ff  <= iss_addr_in;
      iss_base_ff  <= iss_base_in;
      iss_first_ff <= iss_first_in;
      chk_base_ff  <= chk_base_in;
      chk_first_ff <= chk_first_in;
      hit_word_ff  <= hit_word_in;
      hit_base_ff  <= hit_base_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_bit_value   = rsp_ff.bit_value;
   assign rsp_found_index = rsp_ff.found_index;
   assign rsp_set_total   = rsp_ff.set_total;

`ifndef SYNTH
   a_mod_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> ($past(state_ff) == S_RD))
      else $error("Bit update without a preceding word read.");

   a_enc_has_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENC) |-> (hit_word_ff != '0))
      else $error("Index encoding started on an empty word.");

   a_pop_bound: assert property (@(posedge clock) disable iff (reset)
      pop_ff <= CNT_W'(POP_CAP))
      else $error("Population count exceeds the number of settable bits.");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !rsp_valid_ff) |=> (rsp_valid && state_ff == S_IDLE))
      else $error("Finished item did not move to the output register.");
`endif

endmodule
